/* design/srcl_pkg.sv */
package srcl_pkg;

    // Byte position saturates here; a message this long matches nothing.
    localparam logic [3:0] POS_MAX = 4'd11;

    // Pattern bytes.
    localparam logic [7:0] BYTE_SOX       = 8'hf0;
    localparam logic [7:0] BYTE_EOX       = 8'hf7;
    localparam logic [7:0] BYTE_UNIV      = 8'h7e;
    localparam logic [7:0] BYTE_GEN_SUBID = 8'h09;
    localparam logic [7:0] BYTE_SUB_L1    = 8'h01;
    localparam logic [7:0] BYTE_SUB_L2    = 8'h03;
    localparam logic [7:0] BYTE_A_ID      = 8'h41;
    localparam logic [7:0] BYTE_A_DEV_MAX = 8'h1f;
    localparam logic [7:0] BYTE_A_MODEL   = 8'h42;
    localparam logic [7:0] BYTE_A_CMD     = 8'h12;
    localparam logic [7:0] BYTE_A_RST_HI  = 8'h40;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] BYTE_7F        = 8'h7f;
    localparam logic [7:0] BYTE_A_MODE_MX = 8'h01;
    localparam logic [7:0] BYTE_B_ID      = 8'h43;
    localparam logic [3:0] NIB_B_DEV      = 4'h1;
    localparam logic [7:0] BYTE_B_MODEL   = 8'h4c;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_GEN_L1   = 3'd1,
        KIND_GEN_L2   = 3'd2,
        KIND_VENDOR_A = 3'd3,
        KIND_VENDOR_B = 3'd4
    } t_kind;

    // One byte handed from the input register to the matcher.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_step;

    // Classification for a final byte, valid in the same cycle as the step.
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_result;

endpackage

/* design/sysex_reset_classifier.sv */
// Classifies a MIDI system-exclusive message fed one byte per word on the slave
// stream, with tlast on the final byte, and returns exactly one word on the master
// stream per message: 0 none, 1 general reset level 1, 2 general reset level 2,
// 3 vendor-A reset or system mode (checksum checked), 4 vendor-B reset. A byte is
// accepted every cycle unless a final byte is stalled; the classification travels
// from the input register through a single matching stage into the output
// register (the result register). While a result waits unread, non-final bytes
// of the next message still flow, and a final byte waits in the input register
// until the result is taken.
module sysex_reset_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] reset_kind, [7:3] zero
);

    logic            r_in_valid;
    logic            r_in_last;
    logic [7:0]      r_in_data;
    logic            n_in_valid;
    logic            r_out_valid;
    srcl_pkg::t_kind r_out_kind;
    logic            n_out_valid;
    logic            stall;
    logic            advance;
    srcl_pkg::t_step   step;
    srcl_pkg::t_result result;

    // A final byte can only move on when the output register is free.
    assign stall         = r_in_valid && r_in_last && r_out_valid && !m_axis_tready;
    assign advance       = r_in_valid && !stall;
    assign s_axis_tready = !stall;

    assign step.valid = advance;
    assign step.last  = r_in_last;
    assign step.data  = r_in_data;

    srcl_matcher u_matcher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
        n_out_valid = r_out_valid;
        if (result.valid) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (result.valid) begin
            r_out_kind <= result.kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_kind};

endmodule

/* design/srcl_matcher.sv */
module srcl_matcher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srcl_pkg::t_step  i_step,
    output srcl_pkg::t_result o_result
);

    logic [3:0] r_pos;
    logic [6:0] r_sum;
    logic       r_um;
    logic [1:0] r_sub;
    logic       r_am;
    logic       r_ar;
    logic       r_amd;
    logic       r_bm;

    logic [3:0] n_pos;
    logic [6:0] n_sum;
    logic       n_um;
    logic [1:0] n_sub;
    logic       n_am;
    logic       n_ar;
    logic       n_amd;
    logic       n_bm;

    // Flags after checking the current byte.
    logic [6:0] m_sum;
    logic       m_um;
    logic [1:0] m_sub;
    logic       m_am;
    logic       m_ar;
    logic       m_amd;
    logic       m_bm;
    logic [7:0] b;
    logic [6:0] cs_expect;
    srcl_pkg::t_kind kind;

    always_comb begin
        b         = i_step.data;
        cs_expect = 7'd0 - r_sum;
        m_sum     = r_sum;
        m_um      = r_um;
        m_sub     = r_sub;
        m_am      = r_am;
        m_ar      = r_ar;
        m_amd     = r_amd;
        m_bm      = r_bm;

        case (r_pos)
            4'd0: begin
                m_um = r_um && (b == srcl_pkg::BYTE_SOX);
                m_am = r_am && (b == srcl_pkg::BYTE_SOX);
                m_bm = r_bm && (b == srcl_pkg::BYTE_SOX);
            end
            4'd1: begin
                m_um = r_um && (b == srcl_pkg::BYTE_UNIV);
                m_am = r_am && (b == srcl_pkg::BYTE_A_ID);
                m_bm = r_bm && (b == srcl_pkg::BYTE_B_ID);
            end
            4'd2: begin
                m_am = r_am && (b <= srcl_pkg::BYTE_A_DEV_MAX);
                m_bm = r_bm && (b[7:4] == srcl_pkg::NIB_B_DEV);
            end
            4'd3: begin
                m_um = r_um && (b == srcl_pkg::BYTE_GEN_SUBID);
                m_am = r_am && (b == srcl_pkg::BYTE_A_MODEL);
                m_bm = r_bm && (b == srcl_pkg::BYTE_B_MODEL);
            end
            4'd4: begin
                if (b == srcl_pkg::BYTE_SUB_L1) begin
                    m_sub = 2'd1;
                end else if (b == srcl_pkg::BYTE_SUB_L2) begin
                    m_sub = 2'd2;
                end else begin
                    m_sub = 2'd0;
                end
                m_am = r_am && (b == srcl_pkg::BYTE_A_CMD);
                m_bm = r_bm && (b == srcl_pkg::BYTE_ZERO);
            end
            4'd5: begin
                m_um  = r_um && (b == srcl_pkg::BYTE_EOX);
                m_ar  = r_ar && (b == srcl_pkg::BYTE_A_RST_HI);
                m_amd = r_amd && (b == srcl_pkg::BYTE_ZERO);
                m_bm  = r_bm && (b == srcl_pkg::BYTE_ZERO);
                m_sum = r_sum + b[6:0];
            end
            4'd6: begin
                m_ar  = r_ar && (b == srcl_pkg::BYTE_ZERO);
                m_amd = r_amd && (b == srcl_pkg::BYTE_ZERO);
                m_bm  = r_bm && (b == srcl_pkg::BYTE_UNIV);
                m_sum = r_sum + b[6:0];
            end
            4'd7: begin
                m_ar  = r_ar && (b == srcl_pkg::BYTE_7F);
                m_amd = r_amd && (b == srcl_pkg::BYTE_7F);
                m_bm  = r_bm && (b == srcl_pkg::BYTE_ZERO);
                m_sum = r_sum + b[6:0];
            end
            4'd8: begin
                m_ar  = r_ar && (b == srcl_pkg::BYTE_ZERO);
                m_amd = r_amd && (b <= srcl_pkg::BYTE_A_MODE_MX);
                m_bm  = r_bm && (b == srcl_pkg::BYTE_EOX);
                m_sum = r_sum + b[6:0];
            end
            4'd9: begin
                // The checksum byte must have its top bit clear.
                m_am = r_am && (b == {1'b0, cs_expect});
            end
            4'd10: begin
                m_am = r_am && (b == srcl_pkg::BYTE_EOX);
            end
            default: begin
            end
        endcase

        kind = srcl_pkg::KIND_NONE;
        if ((r_pos == 4'd5) && m_um && (m_sub != 2'd0)) begin
            kind = srcl_pkg::t_kind'({1'b0, m_sub});
        end else if ((r_pos == 4'd10) && m_am && (m_ar || m_amd)) begin
            kind = srcl_pkg::KIND_VENDOR_A;
        end else if ((r_pos == 4'd8) && m_bm) begin
            kind = srcl_pkg::KIND_VENDOR_B;
        end

        n_pos = r_pos;
        n_sum = r_sum;
        n_um  = r_um;
        n_sub = r_sub;
        n_am  = r_am;
        n_ar  = r_ar;
        n_amd = r_amd;
        n_bm  = r_bm;
        if (i_step.valid) begin
            if (i_step.last) begin
                n_pos = 4'd0;
                n_sum = 7'd0;
                n_um  = 1'b1;
                n_sub = 2'd0;
                n_am  = 1'b1;
                n_ar  = 1'b1;
                n_amd = 1'b1;
                n_bm  = 1'b1;
            end else begin
                n_pos = (r_pos < srcl_pkg::POS_MAX) ? r_pos + 4'd1 : srcl_pkg::POS_MAX;
                n_sum = m_sum;
                n_um  = m_um;
                n_sub = m_sub;
                n_am  = m_am;
                n_ar  = m_ar;
                n_amd = m_amd;
                n_bm  = m_bm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
            r_sum <= 7'd0;
            r_um  <= 1'b1;
            r_sub <= 2'd0;
            r_am  <= 1'b1;
            r_ar  <= 1'b1;
            r_amd <= 1'b1;
            r_bm  <= 1'b1;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_um  <= n_um;
            r_sub <= n_sub;
            r_am  <= n_am;
            r_ar  <= n_ar;
            r_amd <= n_amd;
            r_bm  <= n_bm;
        end
    end

    assign o_result.valid = i_step.valid && i_step.last;
    assign o_result.kind  = kind;

    a_pos_clears_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && i_step.last) |=> (r_pos == 4'd0) && (r_sum == 7'd0))
        else $error("position or checksum not cleared after final byte");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= srcl_pkg::POS_MAX)
        else $error("byte position beyond saturation");

    a_kind_only_at_pattern_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.kind != srcl_pkg::KIND_NONE)) |->
        ((r_pos == 4'd5) || (r_pos == 4'd8) || (r_pos == 4'd10)))
        else $error("classification at a length no pattern has");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step.valid |=> $stable(r_pos) && $stable(r_sum))
        else $error("matcher state moved without a byte");

endmodule
